>>> hw/rtl/prt_pkg.sv
// ----------------------------------------------------------------------------
// Prime test package
// Shared widths, limits and control structures for the prime test block.
// ----------------------------------------------------------------------------
package prt_pkg;

   localparam int NUMBER_BITS   = 23;
   localparam int COUNT_BITS    = 24;
   localparam int SUM_BITS      = 48;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = COUNT_BITS + SUM_BITS;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [SUM_BITS-1:0]   SUM_MAX   = {SUM_BITS{1'b1}};

   // Status of the shared remainder unit.
   typedef struct packed {
      logic busy;
      logic done;
      logic zero;
   } rem_status_type;

   // Update request for the running count and sum.
   typedef struct packed {
      logic update;
      logic restart;
      logic prime;
   } tally_cmd_type;

endpackage

>>> hw/rtl/prt_rem.sv
// ----------------------------------------------------------------------------
// Prime test remainder unit
// Restoring division, one quotient bit per cycle; reports whether the
// remainder of dividend by divisor is zero.
// ----------------------------------------------------------------------------
module prt_rem #(
   parameter int VALUE_BITS = 23
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [VALUE_BITS-1:0]     dividend,
   input  logic [VALUE_BITS-1:0]     divisor,
   output prt_pkg::rem_status_type   status
);

   localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  zero_ff, zero_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] dvd_ff, dvd_in;
   logic [CNT_BITS-1:0]   cnt_ff, cnt_in;

   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   diff;
   logic                  fits;
   logic [VALUE_BITS-1:0] rem_next;

   always_comb begin
      trial    = {rem_ff, dvd_ff[VALUE_BITS-1]};
      diff     = trial - {1'b0, divisor};
      fits     = trial >= {1'b0, divisor};
      // The partial remainder stays below the divisor, so it fits the narrow width.
      rem_next = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = '0;
         dvd_in  = dividend;
         cnt_in  = CNT_BITS'(VALUE_BITS);
      end else if (busy_ff) begin
         rem_in = rem_next;
         dvd_in = {dvd_ff[VALUE_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            zero_in = (rem_next == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      cnt_ff  <= cnt_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign status.zero = zero_ff;

endmodule

>>> hw/rtl/prt_tally.sv
// ----------------------------------------------------------------------------
// Prime test tally
// Running count and saturating running sum of the primes seen.
// ----------------------------------------------------------------------------
module prt_tally #(
   parameter int VALUE_BITS = 23
) (
   input  logic                             clock,
   input  logic                             reset,
   input  prt_pkg::tally_cmd_type           cmd,
   input  logic [VALUE_BITS-1:0]            value,
   output logic [prt_pkg::COUNT_BITS-1:0]   count,
   output logic [prt_pkg::SUM_BITS-1:0]     sum
);

   logic [prt_pkg::COUNT_BITS-1:0] count_ff, count_in;
   logic [prt_pkg::SUM_BITS-1:0]   sum_ff, sum_in;

   logic [prt_pkg::COUNT_BITS-1:0] base_count;
   logic [prt_pkg::SUM_BITS-1:0]   base_sum;
   logic [prt_pkg::SUM_BITS:0]     sum_wide;
   logic [prt_pkg::COUNT_BITS-1:0] count_inc;
   logic [prt_pkg::SUM_BITS-1:0]   sum_inc;

   always_comb begin
      base_count = cmd.restart ? '0 : count_ff;
      base_sum   = cmd.restart ? '0 : sum_ff;
      sum_wide   = {1'b0, base_sum} + (prt_pkg::SUM_BITS + 1)'(value);
      count_inc  = (base_count == prt_pkg::COUNT_MAX) ? base_count
                                                      : base_count
                                                        + (prt_pkg::COUNT_BITS)'(1);
      sum_inc    = sum_wide[prt_pkg::SUM_BITS] ? prt_pkg::SUM_MAX
                                               : sum_wide[prt_pkg::SUM_BITS-1:0];
      count_in   = count_ff;
      sum_in     = sum_ff;
      if (cmd.update) begin
         count_in = cmd.prime ? count_inc : base_count;
         sum_in   = cmd.prime ? sum_inc   : base_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

   assign count = count_ff;
   assign sum   = sum_ff;

endmodule

>>> hw/rtl/prime_test_count_sum.sv
// ----------------------------------------------------------------------------
// Prime test with running count and sum
// Trial-division primality test over a shared remainder unit, with a running
// tally of the primes seen.
// ----------------------------------------------------------------------------
// One request transaction is taken at a time and yields one response
// transaction. Values below four and even values are settled without any
// division. Other values are divided by the odd numbers from 3 upward while
// the divisor squared is at most the value; each divisor is tried in the
// single restoring remainder unit. The request side is ready only while no
// item is in work; a finished response waits in the output register while
// the next request is taken.
module prime_test_count_sum #(
   parameter int VALUE_BITS = 23
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // Bits from low up: number (23), zero pad (1).
   input  logic [prt_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // Bits from low up: restart (1).
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // Bits from low up: prime_count (24), prime_sum (48).
   output logic [prt_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // Bits from low up: is_prime (1).
   output logic                                rsp_tuser
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_PREP   = 3'd1;
   localparam logic [2:0] S_TEST   = 3'd2;
   localparam logic [2:0] S_WAIT   = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   localparam int NB = prt_pkg::NUMBER_BITS;

   logic [2:0]            state_ff, state_in;
   logic [VALUE_BITS-1:0] n_ff, n_in;
   logic                  restart_ff, restart_in;
   logic [VALUE_BITS-1:0] d_ff, d_in;
   logic [VALUE_BITS+1:0] sq_ff, sq_in;
   logic                  prime_ff, prime_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_prime_ff, rsp_prime_in;

   logic [NB+VALUE_BITS-1:0]       num_wide;
   logic                           req_take;
   logic                           rsp_free;
   logic                           rem_start;
   prt_pkg::rem_status_type        rem_status;
   prt_pkg::tally_cmd_type         tally_cmd;
   logic [prt_pkg::COUNT_BITS-1:0] count;
   logic [prt_pkg::SUM_BITS-1:0]   sum;

   // Number bits above VALUE_BITS are dropped; missing ones read as zero.
   assign num_wide   = {{VALUE_BITS{1'b0}}, req_tdata[NB-1:0]};
   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      restart_in    = restart_ff;
      d_in          = d_ff;
      sq_in         = sq_ff;
      prime_in      = prime_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_prime_in  = rsp_prime_ff;
      rem_start     = 1'b0;
      tally_cmd     = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               n_in       = num_wide[VALUE_BITS-1:0];
               restart_in = req_tuser;
               state_in   = S_PREP;
            end
         end
         S_PREP: begin
            d_in  = VALUE_BITS'(3);
            sq_in = (VALUE_BITS + 2)'(9);
            if (n_ff < VALUE_BITS'(2)) begin
               prime_in = 1'b0;
               state_in = S_FINISH;
            end else if (n_ff < VALUE_BITS'(4)) begin
               prime_in = 1'b1;
               state_in = S_FINISH;
            end else if (!n_ff[0]) begin
               prime_in = 1'b0;
               state_in = S_FINISH;
            end else begin
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if (sq_ff > {2'b00, n_ff}) begin
               prime_in = 1'b1;
               state_in = S_FINISH;
            end else begin
               rem_start = 1'b1;
               state_in  = S_WAIT;
            end
         end
         S_WAIT: begin
            if (rem_status.done) begin
               if (rem_status.zero) begin
                  prime_in = 1'b0;
                  state_in = S_FINISH;
               end else begin
                  // (d + 2)^2 = d^2 + 4d + 4
                  d_in     = d_ff + VALUE_BITS'(2);
                  sq_in    = sq_ff + {d_ff, 2'b00} + (VALUE_BITS + 2)'(4);
                  state_in = S_TEST;
               end
            end
         end
         S_FINISH: begin
            if (rsp_free) begin
               tally_cmd.update  = 1'b1;
               tally_cmd.restart = restart_ff;
               tally_cmd.prime   = prime_ff;
               rsp_valid_in      = 1'b1;
               rsp_prime_in      = prime_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      restart_ff   <= restart_in;
      d_ff         <= d_in;
      sq_ff        <= sq_in;
      prime_ff     <= prime_in;
      rsp_prime_ff <= rsp_prime_in;
   end

   prt_rem #(
      .VALUE_BITS (VALUE_BITS)
   ) u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (n_ff),
      .divisor  (d_ff),
      .status   (rem_status)
   );

   prt_tally #(
      .VALUE_BITS (VALUE_BITS)
   ) u_tally (
      .clock (clock),
      .reset (reset),
      .cmd   (tally_cmd),
      .value (n_ff),
      .count (count),
      .sum   (sum)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {sum, count};
   assign rsp_tuser  = rsp_prime_ff;

   // The remainder unit runs only while the sequencer waits on it.
   a_rem_busy_in_wait: assert property (@(posedge clock) disable iff (reset)
      rem_status.busy |-> (state_ff == S_WAIT))
      else $error("remainder unit busy outside the wait state");

   // A divisor is tried only while its square does not exceed the number.
   a_square_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) |-> (sq_ff <= {2'b00, n_ff}))
      else $error("trial divisor beyond the square root bound");

   // The tally moves only when a transaction is finished.
   a_tally_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_FINISH) |=> ($stable(count) && $stable(sum)))
      else $error("tally changed outside finish");

   // A prime verdict always comes with a nonzero count.
   a_prime_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (count != '0))
      else $error("prime reported with zero count");

endmodule
